FILE: src/sab_pkg.sv
// ----------------------------------------------------------------------------
// sab_pkg: shared types and constants of the servo bank
// Field widths, command and register codes, and the structs between modules.
// ----------------------------------------------------------------------------
package sab_pkg;

	localparam int NUM_SERVOS_DEF = 18;

	localparam int CMD_W   = 2;
	localparam int IDX_IN_W = 5;
	localparam int ANGLE_W = 16;
	localparam int CH_W    = 5;
	localparam int TICK_W  = 13;

	localparam int MASK_W  = 18;
	localparam int AMIN_W  = 11;
	localparam int AMAX_W  = 10;
	localparam int US_W    = 15;

	// clamped angle always fits the width of angle_min
	localparam int CLAMP_W = AMIN_W;

	// shared multiplier operands and product
	localparam int MUL_A_W = 22;
	localparam int MUL_B_W = 23;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	// |angle| * span is at most 1024 * 32767
	localparam int PROD_W  = 25;

	// 1800 = 8 * 225 and us * 4096 / 20000 = (us << 7) / 625, both divisions
	// done as a multiply by the rounded-up reciprocal scaled by 2^30
	localparam int SPAN_PRE_SHIFT   = 3;
	localparam int US_TO_TICK_SHIFT = 7;
	localparam int RECIP_SHIFT      = 30;
	localparam logic [MUL_B_W-1:0] RECIP_225 = 23'd4772186;
	localparam logic [MUL_B_W-1:0] RECIP_625 = 23'd1717987;

	localparam int ANGLE_SPAN  = 1800;
	localparam int FRAME_US    = 20000;
	localparam int FRAME_SHIFT = 12;
	localparam logic [TICK_W-1:0] CENTER_TICK_RESET = 13'd307;

	localparam logic [CMD_W-1:0] CMD_SET     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_COMMIT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

	localparam int CFG_ADDR_W = 5;
	localparam int REG_SEL_W  = 3;
	localparam logic [REG_SEL_W-1:0] REG_DIR_MASK  = 3'd0;
	localparam logic [REG_SEL_W-1:0] REG_ANGLE_MIN = 3'd1;
	localparam logic [REG_SEL_W-1:0] REG_ANGLE_MAX = 3'd2;
	localparam logic [REG_SEL_W-1:0] REG_CENTER    = 3'd3;
	localparam logic [REG_SEL_W-1:0] REG_SPAN      = 3'd4;
	localparam logic [REG_SEL_W-1:0] REG_DRIVER    = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic [IDX_IN_W-1:0]       servo_index;
		logic signed [ANGLE_W-1:0] angle_tenths;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0]   channel;
		logic              on_count;
		logic [TICK_W-1:0] off_count;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [MASK_W-1:0]        direction_mask;
		logic signed [AMIN_W-1:0] angle_min;
		logic [AMAX_W-1:0]        angle_max;
		logic [US_W-1:0]          center_us;
		logic [US_W-1:0]          span_us;
		logic                     driver_present;
	} cfg_t;

	typedef struct packed {
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

FILE: src/sab_cfg_regs.sv
// ----------------------------------------------------------------------------
// sab_cfg_regs: configuration registers
// APB-style register file holding the mapping setup of the servo bank.
// ----------------------------------------------------------------------------
module sab_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sab_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output sab_pkg::cfg_t                   cfg
);

	sab_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [sab_pkg::REG_SEL_W-1:0] sel;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign sel    = paddr[sab_pkg::CFG_ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction_mask <= '0;
			cfg_q.angle_min      <= -11'sd900;
			cfg_q.angle_max      <= 10'd900;
			cfg_q.center_us      <= 15'd1500;
			cfg_q.span_us        <= 15'd2000;
			cfg_q.driver_present <= 1'b0;
		end else if (wr_en) begin
			case (sel)
				sab_pkg::REG_DIR_MASK: begin
					cfg_q.direction_mask <= pwdata[sab_pkg::MASK_W-1:0];
				end
				sab_pkg::REG_ANGLE_MIN: begin
					cfg_q.angle_min <= $signed(pwdata[sab_pkg::AMIN_W-1:0]);
				end
				sab_pkg::REG_ANGLE_MAX: begin
					cfg_q.angle_max <= pwdata[sab_pkg::AMAX_W-1:0];
				end
				sab_pkg::REG_CENTER: begin
					cfg_q.center_us <= pwdata[sab_pkg::US_W-1:0];
				end
				sab_pkg::REG_SPAN: begin
					cfg_q.span_us <= pwdata[sab_pkg::US_W-1:0];
				end
				sab_pkg::REG_DRIVER: begin
					cfg_q.driver_present <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (sel)
			sab_pkg::REG_DIR_MASK:  prdata = 32'(cfg_q.direction_mask);
			sab_pkg::REG_ANGLE_MIN: prdata = 32'(unsigned'(cfg_q.angle_min));
			sab_pkg::REG_ANGLE_MAX: prdata = 32'(cfg_q.angle_max);
			sab_pkg::REG_CENTER:    prdata = 32'(cfg_q.center_us);
			sab_pkg::REG_SPAN:      prdata = 32'(cfg_q.span_us);
			sab_pkg::REG_DRIVER:    prdata = 32'(cfg_q.driver_present);
			default:                prdata = '0;
		endcase
	end

endmodule

FILE: src/sab_div.sv
// ----------------------------------------------------------------------------
// sab_div: shared multiplier
// Unsigned product for the angle scaling and for both divisions by constants.
// ----------------------------------------------------------------------------
module sab_div (
	input  sab_pkg::mul_req_t             req,
	output logic [sab_pkg::MUL_P_W-1:0]   product
);

	assign product = sab_pkg::MUL_P_W'(req.a) * sab_pkg::MUL_P_W'(req.b);

endmodule

FILE: src/servo_angle_to_pwm_bank.sv
// ----------------------------------------------------------------------------
// servo_angle_to_pwm_bank: servo angle to PWM tick bank
// Maps per-channel angles to 50 Hz PWM off ticks and emits them on commit, or zero ticks on release.
// ----------------------------------------------------------------------------
// Usage:
//   An item (command, servo_index, angle_tenths) is taken at a clock edge with
//   start high and busy low. Registers are to be written over the APB-style port
//   only while the bank is idle (not enforced by the bank); pready is always high.
//   A set command runs four steps on one shared multiplier: angle times span,
//   the divisions by 1800 and 20000 as reciprocal multiplies, with the center
//   add and saturation in between; busy stays high until the tick is stored.
//   A commit or release walks the tick store, one channel per cycle; each
//   result is registered in the emit state and the results follow back to
//   back, the last one flagged.
//   Ignored items (no driver, bad channel, unknown command, commit after
//   release) keep busy low, so the next item can follow in the next cycle.
//   Results are shown for one cycle under strobe; the receiver cannot stall.
//   Reset loads every store entry with the center tick, enables the bank and
//   emits nothing.
// ----------------------------------------------------------------------------
module servo_angle_to_pwm_bank #(
	parameter int NUM_SERVOS = sab_pkg::NUM_SERVOS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  sab_pkg::item_t                  req,
	output logic                            busy,
	output logic                            strobe,
	output sab_pkg::result_t                result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sab_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
	localparam logic [sab_pkg::CH_W-1:0] LAST_CH = sab_pkg::CH_W'(NUM_SERVOS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV1 = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_DIV2 = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	sab_pkg::cfg_t     cfg;
	sab_pkg::mul_req_t mul_req;
	logic [sab_pkg::MUL_P_W-1:0] mul_prod;

	logic [2:0]                          state_q;
	logic                                bank_en_q;
	logic                                zeros_q;
	logic [sab_pkg::CH_W-1:0]            ch_q;
	logic [IDX_W-1:0]                    idx_q;
	logic signed [sab_pkg::CLAMP_W-1:0]  angle_q;
	logic [sab_pkg::PROD_W-1:0]          prod_q;
	logic [sab_pkg::US_W-1:0]            quo_q;
	logic [sab_pkg::US_W-1:0]            us_q;
	logic [sab_pkg::TICK_W-1:0]          store_q [NUM_SERVOS];
	logic                                strobe_q;
	sab_pkg::result_t                    result_q;

	logic                                accept;
	logic                                idx_ok;
	logic [31:0]                         mask_ext;
	logic signed [sab_pkg::ANGLE_W:0]    ang_rev;
	logic signed [sab_pkg::ANGLE_W:0]    amin_ext;
	logic signed [sab_pkg::ANGLE_W:0]    amax_ext;
	logic signed [sab_pkg::ANGLE_W:0]    ang_clamp;
	logic [sab_pkg::CLAMP_W-1:0]         ang_mag;
	logic signed [sab_pkg::US_W+2:0]     q_signed;
	logic signed [sab_pkg::US_W+2:0]     us_sum;
	logic [sab_pkg::US_W-1:0]            us_sat;

	sab_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sab_div u_div (
		.req     (mul_req),
		.product (mul_prod)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start & ~busy;
	assign idx_ok = (32'(req.servo_index) < 32'(NUM_SERVOS));

	// channels above the mask width are never reversed
	assign mask_ext = 32'(cfg.direction_mask);

	always_comb begin
		if (mask_ext[req.servo_index]) begin
			if (req.angle_tenths == {1'b1, {(sab_pkg::ANGLE_W-1){1'b0}}}) begin
				ang_rev = {2'b00, {(sab_pkg::ANGLE_W-1){1'b1}}};
			end else begin
				ang_rev = -(sab_pkg::ANGLE_W+1)'(req.angle_tenths);
			end
		end else begin
			ang_rev = (sab_pkg::ANGLE_W+1)'(req.angle_tenths);
		end
		amin_ext = (sab_pkg::ANGLE_W+1)'(cfg.angle_min);
		amax_ext = $signed({{(sab_pkg::ANGLE_W+1-sab_pkg::AMAX_W){1'b0}}, cfg.angle_max});
		ang_clamp = ang_rev;
		if (ang_clamp < amin_ext) begin
			ang_clamp = amin_ext;
		end
		// empty range: the upper bound wins
		if (ang_clamp > amax_ext) begin
			ang_clamp = amax_ext;
		end
	end

	assign ang_mag = angle_q[sab_pkg::CLAMP_W-1] ? unsigned'(-angle_q) : unsigned'(angle_q);

	// the product is split into magnitude and sign, so the quotient truncates toward zero
	always_comb begin
		q_signed = $signed({3'b000, quo_q});
		if (angle_q[sab_pkg::CLAMP_W-1]) begin
			q_signed = -q_signed;
		end
		us_sum = $signed({3'b000, cfg.center_us}) + q_signed;
		if (us_sum < 0) begin
			us_sat = '0;
		end else if (us_sum > (sab_pkg::US_W+3)'(sab_pkg::FRAME_US)) begin
			us_sat = sab_pkg::US_W'(sab_pkg::FRAME_US);
		end else begin
			us_sat = us_sum[sab_pkg::US_W-1:0];
		end
	end

	always_comb begin
		case (state_q)
			ST_DIV1: begin
				mul_req.a = prod_q[sab_pkg::PROD_W-1:sab_pkg::SPAN_PRE_SHIFT];
				mul_req.b = sab_pkg::RECIP_225;
			end
			ST_DIV2: begin
				mul_req.a = sab_pkg::MUL_A_W'({us_q, {sab_pkg::US_TO_TICK_SHIFT{1'b0}}});
				mul_req.b = sab_pkg::RECIP_625;
			end
			default: begin
				mul_req.a = sab_pkg::MUL_A_W'(ang_mag);
				mul_req.b = sab_pkg::MUL_B_W'(cfg.span_us);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bank_en_q <= 1'b1;
			zeros_q   <= 1'b0;
			ch_q      <= '0;
			strobe_q  <= 1'b0;
			for (int i = 0; i < NUM_SERVOS; i++) begin
				store_q[i] <= sab_pkg::CENTER_TICK_RESET;
			end
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && cfg.driver_present) begin
						ch_q <= '0;
						if (req.command == sab_pkg::CMD_SET) begin
							if (idx_ok) begin
								state_q <= ST_MUL;
							end
						end else if (req.command == sab_pkg::CMD_COMMIT) begin
							if (bank_en_q) begin
								zeros_q <= 1'b0;
								state_q <= ST_EMIT;
							end
						end else if (req.command == sab_pkg::CMD_RELEASE) begin
							zeros_q   <= 1'b1;
							bank_en_q <= 1'b0;
							state_q   <= ST_EMIT;
						end
					end
				end
				ST_MUL:  state_q <= ST_DIV1;
				ST_DIV1: state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_DIV2;
				ST_DIV2: begin
					store_q[idx_q] <= mul_prod[sab_pkg::RECIP_SHIFT +: sab_pkg::TICK_W];
					state_q        <= ST_IDLE;
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					ch_q     <= ch_q + 1'b1;
					if (ch_q == LAST_CH) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q   <= req.servo_index[IDX_W-1:0];
			angle_q <= ang_clamp[sab_pkg::CLAMP_W-1:0];
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_prod[sab_pkg::PROD_W-1:0];
		end
		if (state_q == ST_DIV1) begin
			quo_q <= mul_prod[sab_pkg::RECIP_SHIFT +: sab_pkg::US_W];
		end
		if (state_q == ST_ADD) begin
			us_q <= us_sat;
		end
		if (state_q == ST_EMIT) begin
			result_q.channel   <= ch_q;
			result_q.on_count  <= 1'b0;
			result_q.off_count <= zeros_q ? '0 : store_q[ch_q[IDX_W-1:0]];
			result_q.last      <= (ch_q == LAST_CH);
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_strobe_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == ST_EMIT))
		else $error("result strobe without an emit cycle");

	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |-> (result.channel == LAST_CH))
		else $error("last flag on a channel other than the final one");

	a_no_driver_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg.driver_present) |=> !busy)
		else $error("item taken without a driver started work");

	a_set_four_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cfg.driver_present && req.command == sab_pkg::CMD_SET && idx_ok)
		|=> (busy [*4] ##1 !busy))
		else $error("set item did not finish in four cycles");

	a_release_disables: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.off_count != '0) |-> bank_en_q)
		else $error("nonzero ticks emitted after release");
`endif

endmodule
